FILE: rtl/ffa_pkg.sv
// Shared types and codes for the first-fit heap allocator.
package ffa_pkg;

    localparam int GRANULE_BYTES = 8;
    localparam int GRAN_SHIFT    = 3;
    localparam int ARENA_DEF     = 65536;
    localparam int HEADER_DEF    = 24;
    localparam int REQ_W         = 24;
    localparam int OFF_W         = 20;
    localparam int THR_W         = 21;
    localparam int NEED_W        = 22;
    localparam int CALC_W        = 25;
    localparam logic [THR_W-1:0] THR_RESET = 21'd131072;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_RESIZE  = 2'd2;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_NULL  = 2'd1;
    localparam logic [1:0] STS_LARGE = 2'd2;
    localparam logic [1:0] STS_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]       action;
        logic [REQ_W-1:0] request_bytes;
        logic [OFF_W-1:0] handle;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFF_W-1:0] offset;
        logic [OFF_W-1:0] copy_bytes;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LOC_CMP,
        ST_LOC_RD,
        ST_RZ_HDR,
        ST_RZ_NXT,
        ST_RZ_MOVE,
        ST_RL_HDR,
        ST_RL_PRV,
        ST_RL_NXT,
        ST_GRAB_START,
        ST_GRAB_RD,
        ST_APPEND,
        ST_TAIL,
        ST_SPLIT,
        ST_SPLIT_WR,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/ffa_hdr_ram.sv
// Block header memory: one write port and one registered read port.
module ffa_hdr_ram
    import ffa_pkg::*;
#(
    parameter int DEPTH = ARENA_DEF,
    parameter int WIDTH = 34
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/first_fit_heap_allocator.sv
// First-fit heap allocator with block split and coalesce, top level.
//
// Input channel s_valid/s_ready/s_data carries one request item: allocate,
// release or resize. Result channel m_valid/m_ready/m_data returns exactly
// one item per request: status, granted offset and bytes to copy.
// The large-request threshold is written through cfg_we/cfg_wdata by the user
// only while idle; the block itself does not enforce this.
// A small sequencer drives one header memory port pair. The first-fit search
// reads one header per cycle; locating a handle passes through a compare
// state and a read state for each block it walks. A request rejected at once
// goes from the dispatch state straight to the result; any other item goes on
// through the locate, resize, release, first-fit or append states.
// A resize that moves locates its block twice. s_ready is high only while the
// sequencer is idle, so the next item can be taken the cycle after a result
// is loaded into the output register.
//
// Reset empties the heap: the chain is marked empty and the heap end is zero;
// the header memory is not cleared, as only written headers are ever read.
// The result waits in an output register; when the receiver stalls, the next
// item is still taken and worked on, and its result waits until the
// output register is free.
module first_fit_heap_allocator
    import ffa_pkg::*;
#(
    parameter int ARENA_GRANULES = ARENA_DEF,
    parameter int HEADER_BYTES   = HEADER_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              cfg_we,
    input  logic [THR_W-1:0]  cfg_wdata
);

    localparam int HDR_G = (HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
    localparam int AW    = $clog2(ARENA_GRANULES);
    localparam int SW    = AW + 1;
    localparam int CW    = CALC_W;
    localparam int HGW   = OFF_W - GRAN_SHIFT;

    typedef struct packed {
        logic [SW-1:0] size;
        logic [AW-1:0] nxt;
        logic          fre;
    } hdr_t;

    localparam int HW = $bits(hdr_t);

    state_t state_reg, state_next;
    logic [1:0]        act_reg, act_next;
    logic [REQ_W-1:0]  req_reg, req_next;
    logic [OFF_W-1:0]  hd_reg, hd_next;
    logic              fmt_reg, fmt_next;
    logic [HGW-1:0]    tgt_reg, tgt_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [AW-1:0]     cur_reg, cur_next;
    logic [AW-1:0]     prev_reg, prev_next;
    logic [AW-1:0]     blk_reg, blk_next;
    logic [AW-1:0]     gaddr_reg, gaddr_next;
    hdr_t              h_reg, h_next;
    logic              rz_reg, rz_next;
    logic              lrel_reg, lrel_next;
    logic              spg_reg, spg_next;
    logic [1:0]        sts_reg, sts_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [OFF_W-1:0]  cp_reg, cp_next;
    logic [AW:0]       heap_end_reg, heap_end_next;
    logic              csv_reg, csv_next;
    logic [THR_W-1:0]  thr_reg;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    hdr_t          ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [HW-1:0] ram_rdata;
    hdr_t          rd;

    ffa_hdr_ram #(
        .DEPTH (ARENA_GRANULES),
        .WIDTH (HW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd = hdr_t'(ram_rdata);

    function automatic logic [OFF_W-1:0] user_off(input logic [AW-1:0] a);
        logic [CW-1:0] t;
        t = CW'(a) + CW'(HDR_G);
        return {t[HGW-1:0], {GRAN_SHIFT{1'b0}}};
    endfunction

    logic [CW-1:0]     round_sum;
    logic [HGW-1:0]    hd_g;
    logic              over_thr;
    logic [CW-1:0]     h_size_ext;
    logic [CW-1:0]     need_ext;
    logic [CW-1:0]     grow_sum;
    logic [CW-1:0]     room;
    hdr_t              merged;

    assign round_sum  = CW'(s_data.request_bytes) + CW'(GRANULE_BYTES - 1);
    assign hd_g       = s_data.handle[OFF_W-1:GRAN_SHIFT];
    assign over_thr   = {need_reg, {GRAN_SHIFT{1'b0}}} >= CW'(thr_reg);
    assign h_size_ext = CW'(h_reg.size);
    assign need_ext   = CW'(need_reg);
    assign grow_sum   = h_size_ext + CW'(HDR_G) + CW'(rd.size);
    assign room       = CW'(ARENA_GRANULES) - CW'(heap_end_reg);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            heap_end_reg <= '0;
            csv_reg      <= 1'b0;
            thr_reg      <= THR_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            heap_end_reg <= heap_end_next;
            csv_reg      <= csv_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        req_reg    <= req_next;
        hd_reg     <= hd_next;
        fmt_reg    <= fmt_next;
        tgt_reg    <= tgt_next;
        need_reg   <= need_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        blk_reg    <= blk_next;
        gaddr_reg  <= gaddr_next;
        h_reg      <= h_next;
        rz_reg     <= rz_next;
        lrel_reg   <= lrel_next;
        spg_reg    <= spg_next;
        sts_reg    <= sts_next;
        off_reg    <= off_next;
        cp_reg     <= cp_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        req_next      = req_reg;
        hd_next       = hd_reg;
        fmt_next      = fmt_reg;
        tgt_next      = tgt_reg;
        need_next     = need_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        blk_next      = blk_reg;
        gaddr_next    = gaddr_reg;
        h_next        = h_reg;
        rz_next       = rz_reg;
        lrel_next     = lrel_reg;
        spg_next      = spg_reg;
        sts_next      = sts_reg;
        off_next      = off_reg;
        cp_next       = cp_reg;
        heap_end_next = heap_end_reg;
        csv_next      = csv_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        ram_we        = 1'b0;
        ram_waddr     = cur_reg;
        ram_wdata     = h_reg;
        ram_raddr     = cur_reg;
        merged        = h_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    act_next  = s_data.action;
                    req_next  = s_data.request_bytes;
                    hd_next   = s_data.handle;
                    need_next = round_sum[GRAN_SHIFT+NEED_W-1:GRAN_SHIFT];
                    fmt_next  = (s_data.handle != '0) &&
                                (s_data.handle[GRAN_SHIFT-1:0] == '0) &&
                                (CW'(hd_g) >= CW'(HDR_G));
                    tgt_next  = hd_g - HGW'(HDR_G);
                    sts_next  = STS_NULL;
                    off_next  = '0;
                    cp_next   = '0;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                cur_next  = '0;
                prev_next = '0;
                if (act_reg == ACT_ALLOC || (act_reg == ACT_RESIZE && hd_reg == '0)) begin
                    if (req_reg == '0) begin
                        state_next = ST_DONE;
                    end else if (over_thr) begin
                        sts_next   = STS_LARGE;
                        state_next = ST_DONE;
                    end else begin
                        rz_next    = 1'b0;
                        state_next = ST_GRAB_START;
                    end
                end else if ((act_reg == ACT_RELEASE || act_reg == ACT_RESIZE) &&
                             fmt_reg && csv_reg) begin
                    lrel_next  = (act_reg == ACT_RELEASE);
                    sts_next   = (act_reg == ACT_RELEASE) ? STS_OK : STS_NULL;
                    state_next = ST_LOC_CMP;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_LOC_CMP: begin
                ram_raddr = cur_reg;
                if (CW'(cur_reg) == CW'(tgt_reg)) begin
                    blk_next   = cur_reg;
                    state_next = lrel_reg ? ST_RL_HDR : ST_RZ_HDR;
                end else begin
                    state_next = ST_LOC_RD;
                end
            end
            ST_LOC_RD: begin
                if (rd.nxt == '0) begin
                    sts_next   = STS_NULL;
                    off_next   = '0;
                    cp_next    = '0;
                    state_next = ST_DONE;
                end else begin
                    prev_next  = cur_reg;
                    cur_next   = rd.nxt;
                    state_next = ST_LOC_CMP;
                end
            end
            ST_RZ_HDR: begin
                h_next = rd;
                if (req_reg == '0) begin
                    // Resize to nothing releases the block.
                    ram_raddr  = blk_reg;
                    state_next = ST_RL_HDR;
                end else if (CW'(rd.size) >= need_ext) begin
                    sts_next   = STS_OK;
                    off_next   = hd_reg;
                    spg_next   = 1'b0;
                    state_next = ST_SPLIT;
                end else if (rd.nxt != '0) begin
                    ram_raddr  = rd.nxt;
                    state_next = ST_RZ_NXT;
                end else begin
                    state_next = ST_RZ_MOVE;
                end
            end
            ST_RZ_NXT: begin
                if (rd.fre && grow_sum >= need_ext) begin
                    h_next.size = SW'(grow_sum);
                    h_next.nxt  = rd.nxt;
                    sts_next    = STS_OK;
                    off_next    = hd_reg;
                    spg_next    = 1'b0;
                    state_next  = ST_SPLIT;
                end else begin
                    state_next = ST_RZ_MOVE;
                end
            end
            ST_RZ_MOVE: begin
                cp_next = {h_size_ext[HGW-1:0], {GRAN_SHIFT{1'b0}}};
                if (over_thr) begin
                    sts_next   = STS_LARGE;
                    off_next   = '0;
                    ram_raddr  = blk_reg;
                    state_next = ST_RL_HDR;
                end else begin
                    rz_next    = 1'b1;
                    state_next = ST_GRAB_START;
                end
            end
            ST_RL_HDR: begin
                merged     = rd;
                merged.fre = 1'b1;
                h_next     = merged;
                if (blk_reg != '0) begin
                    ram_raddr  = prev_reg;
                    state_next = ST_RL_PRV;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = blk_reg;
                    ram_wdata = merged;
                    ram_raddr = merged.nxt;
                    state_next = (merged.nxt != '0) ? ST_RL_NXT : ST_DONE;
                end
            end
            ST_RL_PRV: begin
                if (rd.fre) begin
                    merged.size = SW'(CW'(rd.size) + h_size_ext + CW'(HDR_G));
                    merged.nxt  = h_reg.nxt;
                    merged.fre  = 1'b1;
                    blk_next    = prev_reg;
                    ram_waddr   = prev_reg;
                end else begin
                    merged    = h_reg;
                    ram_waddr = blk_reg;
                end
                ram_we     = 1'b1;
                ram_wdata  = merged;
                h_next     = merged;
                ram_raddr  = merged.nxt;
                state_next = (merged.nxt != '0) ? ST_RL_NXT : ST_DONE;
            end
            ST_RL_NXT: begin
                if (rd.fre) begin
                    merged.size = SW'(grow_sum);
                    merged.nxt  = rd.nxt;
                    ram_we      = 1'b1;
                    ram_waddr   = blk_reg;
                    ram_wdata   = merged;
                end
                state_next = ST_DONE;
            end
            ST_GRAB_START: begin
                cur_next  = '0;
                ram_raddr = '0;
                state_next = csv_reg ? ST_GRAB_RD : ST_APPEND;
            end
            ST_GRAB_RD: begin
                h_next = rd;
                if (rd.fre && CW'(rd.size) >= need_ext) begin
                    spg_next   = 1'b1;
                    off_next   = user_off(cur_reg);
                    state_next = ST_SPLIT;
                end else if (rd.nxt == '0) begin
                    state_next = ST_APPEND;
                end else begin
                    cur_next  = rd.nxt;
                    ram_raddr = rd.nxt;
                end
            end
            ST_APPEND: begin
                if (need_ext + CW'(HDR_G) > room) begin
                    sts_next   = STS_FULL;
                    off_next   = '0;
                    cp_next    = '0;
                    state_next = ST_DONE;
                end else begin
                    ram_we         = 1'b1;
                    ram_waddr      = AW'(heap_end_reg);
                    ram_wdata.size = SW'(need_reg);
                    ram_wdata.nxt  = '0;
                    ram_wdata.fre  = 1'b0;
                    gaddr_next     = AW'(heap_end_reg);
                    off_next       = user_off(AW'(heap_end_reg));
                    heap_end_next  = (AW + 1)'(CW'(heap_end_reg) + need_ext + CW'(HDR_G));
                    csv_next       = 1'b1;
                    sts_next       = STS_OK;
                    if (csv_reg) begin
                        state_next = ST_TAIL;
                    end else if (rz_reg) begin
                        cur_next   = '0;
                        prev_next  = '0;
                        lrel_next  = 1'b1;
                        state_next = ST_LOC_CMP;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_TAIL: begin
                ram_we        = 1'b1;
                ram_waddr     = cur_reg;
                ram_wdata.nxt = gaddr_reg;
                cur_next      = '0;
                prev_next     = '0;
                lrel_next     = 1'b1;
                state_next    = rz_reg ? ST_LOC_CMP : ST_DONE;
            end
            ST_SPLIT: begin
                if (h_size_ext >= need_ext + CW'(HDR_G + 1)) begin
                    ram_we         = 1'b1;
                    ram_waddr      = AW'(CW'(cur_reg) + CW'(HDR_G) + need_ext);
                    ram_wdata.size = SW'(h_size_ext - need_ext - CW'(HDR_G));
                    ram_wdata.nxt  = h_reg.nxt;
                    ram_wdata.fre  = 1'b1;
                    h_next.size    = SW'(need_reg);
                    h_next.nxt     = AW'(CW'(cur_reg) + CW'(HDR_G) + need_ext);
                end
                state_next = ST_SPLIT_WR;
            end
            ST_SPLIT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = h_reg;
                if (spg_reg) begin
                    ram_wdata.fre = 1'b0;
                    sts_next      = STS_OK;
                end
                if (spg_reg && rz_reg) begin
                    // The request moved: the old block goes back to the heap.
                    cur_next   = '0;
                    prev_next  = '0;
                    lrel_next  = 1'b1;
                    state_next = ST_LOC_CMP;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next.status     = sts_reg;
                    m_data_next.offset     = off_reg;
                    m_data_next.copy_bytes = cp_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_heap_end_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(heap_end_reg) <= CW'(ARENA_GRANULES))
        else $error("heap end beyond arena");

    a_empty_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        !csv_reg |-> heap_end_reg == '0)
        else $error("empty chain with nonzero heap end");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item taken while busy");

    a_ok_has_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STS_OK && m_data.copy_bytes != '0 |->
        m_data.offset != '0)
        else $error("moved block without offset");

    a_large_no_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STS_LARGE |-> m_data.offset == '0)
        else $error("large request granted space");
`endif

endmodule
